[rtl/core/sle_pkg.sv]
// ----------------------------------------------------------------------------
// sle_pkg
// shared constants, command codes and controller/datapath link types for the
// sequential list engine
// ----------------------------------------------------------------------------
`default_nettype none

package sle_pkg;

    // list storage
    localparam int DEPTH      = 256;
    localparam int DATA_WIDTH = 32;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);

    // item fields
    localparam int CMD_W  = 3;
    localparam int POS_W  = 9;
    localparam int IN_RAW = CMD_W + POS_W + DATA_WIDTH;
    localparam int IN_W   = ((IN_RAW + 7) / 8) * 8;
    localparam int OUT_RAW = 1 + DATA_WIDTH + POS_W + CNT_W + 1;
    localparam int OUT_W   = ((OUT_RAW + 7) / 8) * 8;
    localparam int OUT_PAD = OUT_W - OUT_RAW;

    // command codes, unused codes fall through to the error result
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT = 3'd1;
    localparam logic [CMD_W-1:0] CMD_DELETE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_GET    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_LOCATE = 3'd4;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd5;

    // controller to datapath
    typedef struct packed {
        logic capture;     // latch the incoming item
        logic scan_start;  // load scan start and end addresses
        logic scan_run;    // issue one memory read and step the address
        logic commit;      // final write, count update, load result
    } ctl_t;

    // datapath to controller
    typedef struct packed {
        logic need_scan;   // command has to walk stored entries
        logic scan_last;   // read address has reached the end address
        logic out_free;    // result register can take a new item
    } sts_t;

endpackage

`default_nettype wire

[rtl/core/sequential_list_engine.sv]
// ----------------------------------------------------------------------------
// sequential_list_engine
// ordered list of signed words with 1-based positions: clear, insert, delete,
// get, locate and remove-all, one result item per command item
// ----------------------------------------------------------------------------
// sequence: the item is taken, decoded, and when stored entries are walked,
//   scanned and drained; the commit then loads the result once the result
//   register is free. No entry is walked for clear, append, rejected commands,
//   or locate or remove-all on an empty list; get walks 1 entry, the others
//   up to the list count
// one item at a time: no new item is taken until the commit is done; the list
//   memory, one read and one write per cycle, sets the walk length
// reset: rst_n clears the count, the controller and the result valid flag;
//   list memory contents are not cleared and need no clearing pass
`default_nettype none

module sequential_list_engine (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    // command items
    input  wire logic                     s_tvalid,
    output logic                          s_tready,
    input  wire logic [sle_pkg::IN_W-1:0] s_tdata,   // cmd, position, value, zero fill
    // result items
    output logic                          m_tvalid,
    input  wire logic                     m_tready,
    output logic [sle_pkg::OUT_W-1:0]     m_tdata    // ok, value_out, found_position,
                                                     // count, empty_res, zero fill
);
    import sle_pkg::*;

    ctl_t ctl;
    sts_t sts;

    // command sequencing: decode, scan, drain, commit
    sle_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .ctl      (ctl)
    );

    // list memory, shifting and compaction, result register
    sle_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .ctl      (ctl),
        .sts      (sts),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

[rtl/core/sle_datapath.sv]
// ----------------------------------------------------------------------------
// sle_datapath
// list memory, scan address generator, shift/compaction write logic and the
// result register
// ----------------------------------------------------------------------------
`default_nettype none

module sle_datapath (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic [sle_pkg::IN_W-1:0] s_tdata,
    input  wire sle_pkg::ctl_t            ctl,
    output sle_pkg::sts_t                 sts,
    input  wire logic                     m_tready,
    output logic                          m_tvalid,
    output logic [sle_pkg::OUT_W-1:0]     m_tdata
);
    import sle_pkg::*;

    // latched item
    logic [CMD_W-1:0]      cmd_reg;
    logic [POS_W-1:0]      pos_reg;
    logic [DATA_WIDTH-1:0] val_reg;

    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;

    // scan
    logic [ADDR_W-1:0]     addr_reg;
    logic [ADDR_W-1:0]     end_reg;
    logic                  desc_reg;
    logic                  rd_vld_reg;
    logic [ADDR_W-1:0]     rd_addr_q_reg;
    logic [DATA_WIDTH-1:0] rdata_reg;

    // per-command gathered values
    logic [CNT_W-1:0]      keep_reg;
    logic [DATA_WIDTH-1:0] word_reg;
    logic                  found_reg;
    logic [POS_W-1:0]      fpos_reg;

    logic                  m_tvalid_reg;
    logic [OUT_W-1:0]      m_tdata_reg;

    logic [DATA_WIDTH-1:0] mem [DEPTH];

    // decode
    logic [POS_W-1:0]      pos_dec;
    logic [CNT_W-1:0]      cnt_dec;
    logic [CNT_W:0]        cnt_inc;
    logic [ADDR_W-1:0]     pos_idx;
    logic [ADDR_W-1:0]     last_idx;
    logic                  in_range;
    logic                  ins_ok;
    logic                  match;
    logic                  need_scan;

    logic [ADDR_W-1:0]     start_addr;
    logic [ADDR_W-1:0]     start_end;
    logic                  start_desc;

    logic                  wr_en;
    logic [ADDR_W-1:0]     wr_addr;
    logic [DATA_WIDTH-1:0] wr_data;

    logic                  res_ok;
    logic [DATA_WIDTH-1:0] res_val;
    logic [POS_W-1:0]      res_fpos;
    logic                  res_empty;

    assign pos_dec  = pos_reg - POS_W'(1);
    assign cnt_dec  = count_reg - CNT_W'(1);
    assign cnt_inc  = {1'b0, count_reg} + (CNT_W+1)'(1);
    assign pos_idx  = pos_dec[ADDR_W-1:0];
    assign last_idx = cnt_dec[ADDR_W-1:0];
    assign in_range = (pos_reg != '0) && (pos_reg <= count_reg);
    assign ins_ok   = (pos_reg != '0) && ({1'b0, pos_reg} <= cnt_inc)
                      && (count_reg < CNT_W'(DEPTH));
    assign match    = (rdata_reg == val_reg);

    always_comb
    begin
        need_scan  = 1'b0;
        start_addr = '0;
        start_end  = last_idx;
        start_desc = 1'b0;
        case (cmd_reg) inside
            CMD_INSERT:
            begin
                // shift entries last..pos-1 up by one, walking downwards
                need_scan  = ins_ok && in_range;
                start_addr = last_idx;
                start_end  = pos_idx;
                start_desc = 1'b1;
            end
            CMD_DELETE:
            begin
                need_scan  = in_range;
                start_addr = pos_idx;
            end
            CMD_GET:
            begin
                need_scan  = in_range;
                start_addr = pos_idx;
                start_end  = pos_idx;
            end
            CMD_LOCATE, CMD_REMOVE:
            begin
                need_scan = (count_reg != '0);
            end
            default:
            begin
                need_scan = 1'b0;
            end
        endcase
    end

    assign sts.need_scan = need_scan;
    assign sts.scan_last = (addr_reg == end_reg);
    assign sts.out_free  = !m_tvalid_reg || m_tready;

    // memory write: shifted or kept entries during the scan, new word at commit
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = rdata_reg;
        if (rd_vld_reg)
        begin
            case (cmd_reg)
                CMD_INSERT:
                begin
                    wr_en   = 1'b1;
                    wr_addr = rd_addr_q_reg + ADDR_W'(1);
                end
                CMD_DELETE:
                begin
                    wr_en   = (rd_addr_q_reg != pos_idx);
                    wr_addr = rd_addr_q_reg - ADDR_W'(1);
                end
                CMD_REMOVE:
                begin
                    wr_en   = !match;
                    wr_addr = keep_reg[ADDR_W-1:0];
                end
                default:
                begin
                    wr_en = 1'b0;
                end
            endcase
        end
        else if (ctl.commit && (cmd_reg == CMD_INSERT) && ins_ok)
        begin
            wr_en   = 1'b1;
            wr_addr = pos_idx;
            wr_data = val_reg;
        end
    end

    // result of the finished item
    always_comb
    begin
        res_ok     = 1'b0;
        count_next = count_reg;
        case (cmd_reg)
            CMD_CLEAR:
            begin
                res_ok     = 1'b1;
                count_next = '0;
            end
            CMD_INSERT:
            begin
                res_ok     = ins_ok;
                count_next = ins_ok ? cnt_inc[CNT_W-1:0] : count_reg;
            end
            CMD_DELETE:
            begin
                res_ok     = in_range;
                count_next = in_range ? cnt_dec : count_reg;
            end
            CMD_GET:
            begin
                res_ok = in_range;
            end
            CMD_LOCATE:
            begin
                res_ok = found_reg;
            end
            CMD_REMOVE:
            begin
                res_ok     = 1'b1;
                count_next = keep_reg;
            end
            default:
            begin
                res_ok = 1'b0;
            end
        endcase
        res_val   = (((cmd_reg == CMD_DELETE) || (cmd_reg == CMD_GET)) && in_range)
                    ? word_reg : '0;
        res_fpos  = ((cmd_reg == CMD_LOCATE) && found_reg) ? fpos_reg : '0;
        res_empty = (count_next == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            rd_vld_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= ctl.scan_run;
            if (ctl.commit)
            begin
                count_reg    <= count_next;
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rd_addr_q_reg <= addr_reg;
        if (ctl.capture)
        begin
            cmd_reg   <= s_tdata[CMD_W-1:0];
            pos_reg   <= s_tdata[CMD_W +: POS_W];
            val_reg   <= s_tdata[CMD_W+POS_W +: DATA_WIDTH];
            keep_reg  <= '0;
            word_reg  <= '0;
            found_reg <= 1'b0;
            fpos_reg  <= '0;
        end
        if (ctl.scan_start)
        begin
            addr_reg <= start_addr;
            end_reg  <= start_end;
            desc_reg <= start_desc;
        end
        else if (ctl.scan_run && !sts.scan_last)
        begin
            addr_reg <= desc_reg ? addr_reg - ADDR_W'(1) : addr_reg + ADDR_W'(1);
        end
        if (rd_vld_reg)
        begin
            case (cmd_reg) inside
                CMD_DELETE, CMD_GET:
                begin
                    if (rd_addr_q_reg == pos_idx)
                    begin
                        word_reg <= rdata_reg;
                    end
                end
                CMD_LOCATE:
                begin
                    if (!found_reg && match)
                    begin
                        found_reg <= 1'b1;
                        fpos_reg  <= POS_W'(rd_addr_q_reg) + POS_W'(1);
                    end
                end
                CMD_REMOVE:
                begin
                    if (!match)
                    begin
                        keep_reg <= keep_reg + CNT_W'(1);
                    end
                end
                default:
                begin
                end
            endcase
        end
        if (ctl.commit)
        begin
            m_tdata_reg <= {{OUT_PAD{1'b0}}, res_empty, count_next, res_fpos,
                            res_val, res_ok};
        end
    end

    // list memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rdata_reg <= mem[addr_reg];
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("list count beyond depth");

    a_keep_bound : assert property (@(posedge clk) disable iff (!rst_n)
        (rd_vld_reg && (cmd_reg == CMD_REMOVE)) |-> (keep_reg < count_reg))
        else $error("compaction index overran the list");

    a_no_rw_clash : assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.scan_run && wr_en) |-> (wr_addr != addr_reg))
        else $error("scan write hits the address being read");

    a_commit_free : assert property (@(posedge clk) disable iff (!rst_n)
        ctl.commit |-> sts.out_free)
        else $error("result loaded over an untaken item");

endmodule

`default_nettype wire

[rtl/core/sle_controller.sv]
// ----------------------------------------------------------------------------
// sle_controller
// sequences one command: decode, memory scan, drain of the last read, commit
// ----------------------------------------------------------------------------
`default_nettype none

module sle_controller (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire sle_pkg::sts_t sts,
    output sle_pkg::ctl_t      ctl
);
    import sle_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_DRAIN,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = sts.need_scan ? S_SCAN : S_DONE;
            end
            S_SCAN:
            begin
                if (sts.scan_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign s_tready       = (state_reg == S_IDLE);
    assign ctl.capture    = (state_reg == S_IDLE) && s_tvalid;
    assign ctl.scan_start = (state_reg == S_DECODE) && sts.need_scan;
    assign ctl.scan_run   = (state_reg == S_SCAN);
    assign ctl.commit     = (state_reg == S_DONE) && sts.out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_one_cmd : assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({ctl.capture, ctl.scan_start, ctl.scan_run, ctl.commit}))
        else $error("more than one datapath command at once");

    a_scan_end : assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.scan_run && sts.scan_last) |=> (state_reg == S_DRAIN))
        else $error("scan did not stop at its end address");

    a_commit_idle : assert property (@(posedge clk) disable iff (!rst_n)
        ctl.commit |=> s_tready)
        else $error("not ready after commit");

endmodule

`default_nettype wire
